[rtl/core/arp_cache_table_with_aging_assert.svh]
// Assertion macros used by the ARP cache RTL.
`ifndef ARP_CACHE_TABLE_WITH_AGING_ASSERT_SVH
`define ARP_CACHE_TABLE_WITH_AGING_ASSERT_SVH

// Same-cycle implication, checked while out of reset.
`define ARPC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked while out of reset.
`define ARPC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/arpc_pkg.sv]
// Types and constants of the ARP cache with timeout aging.
package arpc_pkg;

  localparam int unsigned ARPC_ENTRIES = 64;
  localparam logic [15:0] TIMEOUT_RST  = 16'd15;

  localparam logic [1:0] MODE_LOOKUP = 2'd0;
  localparam logic [1:0] MODE_INSERT = 2'd1;
  localparam logic [1:0] MODE_TICK   = 2'd2;

  localparam logic [6:0] EXPIRED_MAX = 7'h7f;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] ip_addr;
    logic [47:0] mac_addr;
  } in_t;

  typedef struct packed {
    logic        hit;
    logic [47:0] found_mac;
    logic        stored;
    logic [6:0]  expired_count;
  } out_t;

  typedef struct packed {
    logic [31:0] ip;
    logic [47:0] mac;
    logic [31:0] stamp;
  } entry_t;

endpackage

[rtl/core/arp_cache_table_with_aging.sv]
// ARP cache table with lookup, insert and timeout aging on one sequencer.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o, word in_data_i) carries one
//   operation: lookup, insert, or a one-second tick. Output channel
//   (out_valid_o / out_stall_i, word out_data_o) returns exactly one result
//   word per operation. A word moves when valid is high and stall is low.
//   Lookup and tick walk the whole table through one memory read port, one
//   entry per cycle, with a single compare unit (IP match or age check).
//   Insert walks the valid bits until the first free slot; an unused mode
//   code goes straight to the finish state and returns an all-zero word.
//   One operation is in flight at a time; the input stalls while it runs.
//   The result sits in an output register, so the next word is accepted while
//   a finished result still waits on a stalled receiver; the sequencer only
//   holds in its finish state if that register is still full.
//   Reset clears all valid bits, the seconds counter and the timeout (to 15);
//   the table contents need no clearing pass. cfg_we_i writes the timeout and
//   is only to be used while the block is idle; the block does not enforce it.
module arp_cache_table_with_aging #(
  parameter int unsigned ENTRIES = arpc_pkg::ARPC_ENTRIES
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  arpc_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output arpc_pkg::out_t out_data_o,
  input  logic           cfg_we_i,
  input  logic [15:0]    cfg_wdata_i
);
  import arpc_pkg::*;

  `include "arp_cache_table_with_aging_assert.svh"

  localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(ENTRIES + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);
  localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(ENTRIES);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS,
    ST_SCAN,
    ST_DONE
  } state_e;

  state_e             state_q;
  in_t                op_q;
  out_t               res_q;
  out_t               out_q;
  logic               out_valid_q;
  logic [ENTRIES-1:0] valid_q;
  logic [31:0]        now_q;
  logic [15:0]        timeout_q;
  logic [CNT_W-1:0]   cnt_q;
  logic               p_vld_q;
  logic [IDX_W-1:0]   p_idx_q;

  // Table contents: one write port (insert), one read port (scan).
  entry_t             mem [ENTRIES];
  entry_t             rd_q;

  logic [IDX_W-1:0]   cnt_idx;
  logic               in_acc;
  logic               out_load;
  logic               mem_we;
  logic               mem_re;
  logic               ip_match;
  logic [31:0]        age;
  logic               expire;
  entry_t             new_entry;

  assign cnt_idx    = cnt_q[IDX_W-1:0];
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && (state_q == ST_IDLE);
  assign out_load   = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);

  assign mem_we  = (state_q == ST_INS) && !valid_q[cnt_idx];
  assign mem_re  = (state_q == ST_SCAN) && (cnt_q < CNT_END);

  // Shared compare unit: one IP match or one age check per cycle.
  assign ip_match = valid_q[p_idx_q] && (rd_q.ip == op_q.ip_addr);
  assign age      = now_q - rd_q.stamp;
  assign expire   = valid_q[p_idx_q] && (age > {16'd0, timeout_q});

  assign new_entry.ip    = op_q.ip_addr;
  assign new_entry.mac   = op_q.mac_addr;
  assign new_entry.stamp = now_q;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[cnt_idx] <= new_entry;
    end
    if (mem_re) begin
      rd_q <= mem[cnt_idx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= '0;
      res_q       <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
      valid_q     <= '0;
      now_q       <= '0;
      timeout_q   <= TIMEOUT_RST;
      cnt_q       <= '0;
      p_vld_q     <= 1'b0;
      p_idx_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        timeout_q <= cfg_wdata_i;
      end

      // Load the output register from a finished operation, else drain it.
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            op_q    <= in_data_i;
            res_q   <= '0;
            cnt_q   <= '0;
            p_vld_q <= 1'b0;
            unique case (in_data_i.mode)
              MODE_LOOKUP: state_q <= ST_SCAN;
              MODE_INSERT: state_q <= ST_INS;
              MODE_TICK: begin
                // Advance time before the aging walk.
                now_q   <= now_q + 32'd1;
                state_q <= ST_SCAN;
              end
              default: state_q <= ST_DONE;
            endcase
          end
        end

        ST_INS: begin
          // Take the lowest free slot, or give up after the last entry.
          if (!valid_q[cnt_idx]) begin
            valid_q[cnt_idx] <= 1'b1;
            res_q.stored     <= 1'b1;
            state_q          <= ST_DONE;
          end else if (cnt_idx == LAST_IDX) begin
            state_q <= ST_DONE;
          end
          cnt_q <= cnt_q + CNT_W'(1);
        end

        ST_SCAN: begin
          // Issue the next read and evaluate the entry read last cycle.
          p_vld_q <= mem_re;
          p_idx_q <= cnt_idx;
          if (mem_re) begin
            cnt_q <= cnt_q + CNT_W'(1);
          end
          if (p_vld_q) begin
            if (op_q.mode == MODE_LOOKUP) begin
              if (ip_match) begin
                res_q.hit       <= 1'b1;
                res_q.found_mac <= rd_q.mac;
              end
            end else if (expire) begin
              valid_q[p_idx_q] <= 1'b0;
              if (res_q.expired_count != EXPIRED_MAX) begin
                res_q.expired_count <= res_q.expired_count + 7'd1;
              end
            end
            if (p_idx_q == LAST_IDX) begin
              state_q <= ST_DONE;
            end
          end
        end

        ST_DONE: begin
          // Hold until the output register is free.
          if (out_load) begin
            out_q   <= res_q;
            state_q <= ST_IDLE;
          end
        end

        default: state_q <= ST_IDLE;
      endcase
    end
  end

  `ARPC_ASSERT_NOW(a_mode_exclusive, clk_i, rst_ni,
                   out_valid_o && out_data_o.hit,
                   !out_data_o.stored && (out_data_o.expired_count == 7'd0),
                   "lookup hit reported together with insert or tick result")
  `ARPC_ASSERT_NOW(a_miss_mac_zero, clk_i, rst_ni,
                   out_valid_o && !out_data_o.hit, out_data_o.found_mac == 48'd0,
                   "nonzero MAC without a lookup hit")
  `ARPC_ASSERT_NEXT(a_tick_advance, clk_i, rst_ni,
                    in_acc && (in_data_i.mode == MODE_TICK),
                    now_q == $past(now_q) + 32'd1,
                    "tick did not advance the seconds counter")
  `ARPC_ASSERT_NEXT(a_insert_fills, clk_i, rst_ni, mem_we,
                    $countones(valid_q) == $past($countones(valid_q)) + 1,
                    "insert did not mark exactly one slot valid")

endmodule

[bench/testbench.sv]
// Self-checking testbench for the ARP cache table with timeout aging.
import arpc_pkg::*;

// Scoreboard: a cycle-free copy of the table plus the queue of result words
// still owed by the block.
class arp_scoreboard;
  bit          live [ARPC_ENTRIES];
  entry_t      slot [ARPC_ENTRIES];
  logic [31:0] now_sec;
  logic [15:0] timeout;
  out_t        owed_q [$];
  int          fails;
  int          checked;
  int          n_words;
  int          n_hits;
  int          n_dropped;
  int          n_expired;

  function new();
    foreach (live[k]) begin
      live[k] = 1'b0;
      slot[k] = '0;
    end
    now_sec = '0;
    timeout = TIMEOUT_RST;
  endfunction

  function void set_timeout(logic [15:0] value);
    timeout = value;
  endfunction

  function int pending();
    return owed_q.size();
  endfunction

  function bit table_full();
    foreach (live[k]) begin
      if (!live[k]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Apply one accepted input word to the table copy and queue its result.
  function void note_word(in_t w);
    out_t        r;
    logic [31:0] age;
    r = '0;
    n_words++;
    case (w.mode)
      MODE_LOOKUP: begin
        // The highest-index match wins, so keep overwriting on the way up.
        for (int k = 0; k < ARPC_ENTRIES; k++) begin
          if (live[k] && slot[k].ip == w.ip_addr) begin
            r.hit       = 1'b1;
            r.found_mac = slot[k].mac;
          end
        end
        if (r.hit) n_hits++;
      end
      MODE_INSERT: begin
        for (int k = 0; k < ARPC_ENTRIES; k++) begin
          if (!live[k]) begin
            slot[k]  = '{ip: w.ip_addr, mac: w.mac_addr, stamp: now_sec};
            live[k]  = 1'b1;
            r.stored = 1'b1;
            break;
          end
        end
        if (!r.stored) n_dropped++;
      end
      MODE_TICK: begin
        now_sec = now_sec + 32'd1;
        for (int k = 0; k < ARPC_ENTRIES; k++) begin
          age = now_sec - slot[k].stamp;
          if (live[k] && age > {16'd0, timeout}) begin
            live[k] = 1'b0;
            if (r.expired_count != EXPIRED_MAX) r.expired_count++;
            n_expired++;
          end
        end
      end
      default: ;
    endcase
    owed_q.push_back(r);
  endfunction

  task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    fails++;
    $display("mismatch at result %0d: %s got %0h, expected %0h", checked, what, got, want);
  endtask

  // Compare one accepted result word with the oldest owed one.
  task check_word(out_t got);
    out_t want;
    checked++;
    if (owed_q.size() == 0) begin
      report_mismatch("unexpected word", 64'(got), 64'd0);
    end else begin
      want = owed_q.pop_front();
      if (got.hit !== want.hit)
        report_mismatch("hit", 64'(got.hit), 64'(want.hit));
      if (got.found_mac !== want.found_mac)
        report_mismatch("found_mac", 64'(got.found_mac), 64'(want.found_mac));
      if (got.stored !== want.stored)
        report_mismatch("stored", 64'(got.stored), 64'(want.stored));
      if (got.expired_count !== want.expired_count)
        report_mismatch("expired_count", 64'(got.expired_count), 64'(want.expired_count));
    end
  endtask

  task close();
    if (owed_q.size() != 0)
      report_mismatch("words never returned", 64'd0, 64'(owed_q.size()));
  endtask
endclass

module testbench;

  // No package constant names the unused mode code; give it one here.
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  // Slowest correct run: ~600 words, each with idle gaps, a full table walk
  // and receiver stalls; the limit allows many times that.
  localparam int LIMIT = 400000;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  in_t         in_data_i   = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_t        out_data_o;
  logic        cfg_we_i    = 1'b0;
  logic [15:0] cfg_wdata_i = '0;

  arp_scoreboard sb;
  bit            calm = 1'b1;   // when set, neither side idles or stalls
  logic [31:0]   ip_pool [8];   // a few addresses reused so lookups can hit
  int            settings;

  arp_cache_table_with_aging u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog: end the run as failed if the block stops making progress.
  initial begin : watchdog
    int cycles;
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > LIMIT) begin
        $display("timeout after %0d cycles", cycles);
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  function automatic in_t mk_word(logic [1:0] mode, logic [31:0] ip, logic [47:0] mac);
    in_t w;
    w.mode     = mode;
    w.ip_addr  = ip;
    w.mac_addr = mac;
    return w;
  endfunction

  // Draw a random operation; mostly pool addresses so the table sees reuse,
  // duplicates and hits, with a small share of the unused mode code.
  function automatic in_t rand_word(int insert_pct, int tick_pct);
    int          r;
    logic [1:0]  mode;
    logic [31:0] ip;
    r = $urandom_range(99);
    if (r < 3)                               mode = MODE_UNUSED;
    else if (r < 3 + tick_pct)               mode = MODE_TICK;
    else if (r < 3 + tick_pct + insert_pct)  mode = MODE_INSERT;
    else                                     mode = MODE_LOOKUP;
    ip = ($urandom_range(3) != 0) ? ip_pool[$urandom_range(7)] : 32'($urandom);
    return mk_word(mode, ip, {16'($urandom), 32'($urandom)});
  endfunction

  // Present one word, hold it while stalled, and note it once accepted.
  // Valid stays high across back-to-back words; drop it only for a gap.
  task automatic send_word(input in_t w);
    int gap;
    gap = calm ? 0 : $urandom_range(8);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_word(w);
  endtask

  // Stop sending and wait until every owed result word has come back.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // Write the timeout register; only called with the block idle.
  task automatic write_timeout(input logic [15:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    sb.set_timeout(value);
    settings++;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_random(int count, int insert_pct, int tick_pct);
    for (int n = 0; n < count; n++) begin
      // Re-draw the idling mode every 40 words so calm stretches appear.
      if (n % 40 == 0) calm = ($urandom_range(3) == 0);
      send_word(rand_word(insert_pct, tick_pct));
    end
  endtask

  // Receiver: stall a random number of cycles per word, then take and check it.
  initial begin : receiver
    int hold;
    @(posedge rst_ni);
    forever begin
      hold = calm ? 0 : $urandom_range(8);
      if (hold != 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
      do @(posedge clk_i); while (!(out_valid_o && !out_stall_i));
      sb.check_word(out_data_o);
    end
  end

  initial begin : stimulus
    sb = new();
    settings = 1;   // the reset value counts as the first setting
    foreach (ip_pool[k]) ip_pool[k] = $urandom;
    ip_pool[0] = 32'h0000_0000;
    ip_pool[1] = 32'hffff_ffff;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed, reset timeout: empty-table miss, field extremes, duplicate
    // insert (the later, higher slot must win), unused mode, first tick.
    calm = 1'b1;
    send_word(mk_word(MODE_LOOKUP, 32'h0000_0000, 48'h0));
    send_word(mk_word(MODE_INSERT, 32'h0000_0000, 48'h0));
    send_word(mk_word(MODE_INSERT, 32'hffff_ffff, 48'hffff_ffff_ffff));
    send_word(mk_word(MODE_LOOKUP, 32'h0000_0000, 48'hffff_ffff_ffff));
    send_word(mk_word(MODE_LOOKUP, 32'hffff_ffff, 48'h0));
    send_word(mk_word(MODE_INSERT, 32'hffff_ffff, 48'h0123_4567_89ab));
    send_word(mk_word(MODE_LOOKUP, 32'hffff_ffff, 48'h0));
    send_word(mk_word(MODE_UNUSED, 32'hffff_ffff, 48'hffff_ffff_ffff));
    send_word(mk_word(MODE_TICK, 32'hffff_ffff, 48'hffff_ffff_ffff));
    send_word(mk_word(MODE_LOOKUP, 32'h1234_5678, 48'h0));
    drain();

    // Zero timeout: every entry dies on the first tick after its insert.
    write_timeout(16'd0);
    send_word(mk_word(MODE_INSERT, 32'h0a00_0001, 48'h5555_aaaa_5555));
    send_word(mk_word(MODE_LOOKUP, 32'h0a00_0001, 48'h0));
    send_word(mk_word(MODE_TICK, 32'h0, 48'h0));
    send_word(mk_word(MODE_LOOKUP, 32'h0a00_0001, 48'h0));
    drain();

    // Maximum timeout: nothing ages out, so inserts fill the table.
    write_timeout(16'hffff);
    send_random(120, 60, 10);
    calm = 1'b0;
    while (!sb.table_full())
      send_word(mk_word(MODE_INSERT, 32'($urandom), {16'($urandom), 32'($urandom)}));
    // Table full: this insert must be dropped.
    send_word(mk_word(MODE_INSERT, ip_pool[2], 48'hdead_beef_0001));
    drain();

    // Zero timeout on a full table: one tick clears all entries at once.
    write_timeout(16'd0);
    send_word(mk_word(MODE_TICK, 32'h0, 48'h0));
    send_word(mk_word(MODE_LOOKUP, ip_pool[2], 48'h0));
    drain();

    // Short timeout: steady churn of inserts, expiries and hits.
    write_timeout(16'd5);
    send_random(250, 35, 20);
    drain();

    write_timeout(16'($urandom_range(40, 1)));
    send_random(100, 40, 15);
    drain();

    // Hold a little longer to catch any stray word after the last one.
    repeat (80) @(posedge clk_i);
    sb.close();

    $display("Covered %0d operations over %0d timeout settings: %0d lookup hits,",
             sb.n_words, settings, sb.n_hits);
    $display("%0d inserts dropped on a full table, %0d entries aged out; %0d words checked.",
             sb.n_dropped, sb.n_expired, sb.checked);
    if (sb.fails == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
